// File: hw/rtl/nearest_palette_color_defines.svh
`ifndef NEAREST_PALETTE_COLOR_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define NPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/npc_pkg.sv
package npc_pkg;

  localparam int COLOR_W = 16;
  localparam int KEY_W   = 8;
  localparam int SQ_W    = 2 * KEY_W;
  localparam int DIST_W  = 18;
  localparam int SIZE_W  = 9;
  localparam int OUT_IDX_W = 8;
  localparam int ENTRY_W = 3 * COLOR_W;

  localparam logic [DIST_W-1:0] DIST_START = 18'd196608;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic capture;
    logic rd_en;
    logic finish;
  } npc_cmd_t;

  typedef struct packed {
    logic found;
    logic idle;
  } npc_status_t;

endpackage

// File: hw/rtl/npc_ctrl.sv
module npc_ctrl
  import npc_pkg::*;
#(
  parameter int IDX_W = 8,
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              opcode,
  input  logic              cfg_valid,
  input  logic [SIZE_W-1:0] cfg_data,
  output logic              cfg_ready,
  output logic              busy,
  output npc_cmd_t          cmd,
  output logic [IDX_W-1:0]  rd_addr,
  input  npc_status_t       status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  localparam int SW = IDX_W + 10;

  state_t            state;
  logic [SIZE_W-1:0] palette_size;
  logic [IDX_W-1:0]  last;
  logic [IDX_W-1:0]  last_next;
  logic [SW-1:0]     size_wide;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign size_wide = SW'(palette_size);

  always_comb begin
    if (size_wide == '0) begin
      last_next = '0;
    end else if (size_wide > SW'(DEPTH)) begin
      last_next = IDX_W'(DEPTH - 1);
    end else begin
      last_next = IDX_W'(size_wide - SW'(1));
    end
  end

  always_comb begin
    cmd.load_wr = accept && (opcode == OP_LOAD);
    cmd.capture = accept && (opcode == OP_QUERY);
    cmd.rd_en   = (state == ST_SCAN) && !status.found;
    cmd.finish  = (state == ST_DRAIN) && status.idle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      busy         <= 1'b0;
      palette_size <= SIZE_RESET;
      rd_addr      <= '0;
      last         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        palette_size <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state   <= ST_SCAN;
            busy    <= 1'b1;
            rd_addr <= '0;
            last    <= last_next;
          end
        end
        ST_SCAN: begin
          if (status.found || rd_addr == last) begin
            state <= ST_DRAIN;
          end else begin
            rd_addr <= rd_addr + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (status.idle) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/npc_datapath.sv
module npc_datapath
  import npc_pkg::*;
#(
  parameter int IDX_W = 8,
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  npc_cmd_t             cmd,
  input  logic [IDX_W-1:0]     rd_addr,
  output npc_status_t          status,
  input  logic [OUT_IDX_W-1:0] entry_index,
  input  logic [COLOR_W-1:0]   red,
  input  logic [COLOR_W-1:0]   green,
  input  logic [COLOR_W-1:0]   blue,
  output logic                 done,
  output logic [OUT_IDX_W-1:0] match_index,
  output logic [COLOR_W-1:0]   match_red,
  output logic [COLOR_W-1:0]   match_green,
  output logic [COLOR_W-1:0]   match_blue
);

  localparam int WW = IDX_W + OUT_IDX_W;

  logic [ENTRY_W-1:0] mem [DEPTH];

  logic [KEY_W-1:0]   q_r, q_g, q_b;
  logic [WW-1:0]      wr_wide;
  logic               wr_ok;

  logic               v1, v2, found;
  logic [IDX_W-1:0]   a1, a2;
  logic [ENTRY_W-1:0] rdata, data2;
  logic [SQ_W-1:0]    sq_r, sq_g, sq_b;

  logic [KEY_W-1:0]   d_r, d_g, d_b;
  logic [DIST_W-1:0]  sum_sq;

  logic [DIST_W-1:0]  best_dist;
  logic [IDX_W-1:0]   best_idx;
  logic [ENTRY_W-1:0] best_data;
  logic [WW-1:0]      best_wide;

  function automatic logic [KEY_W-1:0] absdiff(input logic [KEY_W-1:0] x,
                                               input logic [KEY_W-1:0] y);
    absdiff = (x > y) ? (x - y) : (y - x);
  endfunction

  assign wr_wide = WW'(entry_index);
  assign wr_ok   = wr_wide < WW'(DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_ok) begin
      mem[wr_wide[IDX_W-1:0]] <= {red, green, blue};
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign d_r = absdiff(rdata[3*COLOR_W-1 -: KEY_W], q_r);
  assign d_g = absdiff(rdata[2*COLOR_W-1 -: KEY_W], q_g);
  assign d_b = absdiff(rdata[COLOR_W-1 -: KEY_W], q_b);

  assign sum_sq = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  assign status.found = found;
  assign status.idle  = !v1 && !v2;

  assign best_wide = WW'(best_idx);

  always_ff @(posedge clk) begin
    a1    <= rd_addr;
    a2    <= a1;
    data2 <= rdata;
    sq_r  <= SQ_W'(d_r) * SQ_W'(d_r);
    sq_g  <= SQ_W'(d_g) * SQ_W'(d_g);
    sq_b  <= SQ_W'(d_b) * SQ_W'(d_b);
    if (cmd.capture) begin
      q_r       <= red[COLOR_W-1 -: KEY_W];
      q_g       <= green[COLOR_W-1 -: KEY_W];
      q_b       <= blue[COLOR_W-1 -: KEY_W];
      best_dist <= DIST_START;
      best_idx  <= '0;
    end else if (v2 && !found && sum_sq < best_dist) begin
      best_dist <= sum_sq;
      best_idx  <= a2;
      best_data <= data2;
    end
    if (cmd.finish) begin
      match_index <= best_wide[OUT_IDX_W-1:0];
      match_red   <= best_data[3*COLOR_W-1 -: COLOR_W];
      match_green <= best_data[2*COLOR_W-1 -: COLOR_W];
      match_blue  <= best_data[COLOR_W-1 -: COLOR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      found <= 1'b0;
      done  <= 1'b0;
    end else begin
      v1   <= cmd.rd_en;
      v2   <= v1;
      done <= cmd.finish;
      if (cmd.capture) begin
        found <= 1'b0;
      end else if (v2 && !found && sum_sq < best_dist && sum_sq == '0) begin
        found <= 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/nearest_palette_color.sv
// Nearest palette color search.
// Command channel: an item is taken on a clock edge with start high and busy
// low. opcode selects a load (writes red/green/blue into entry entry_index)
// or a query (finds the nearest entry to red/green/blue on the upper bytes).
// A load leaves busy low; loads may stream every cycle.
// A query raises busy and scans entries 0..N-1, N = palette_size clamped to
// 1..PALETTE_DEPTH, one entry per cycle through a single distance unit fed by
// the palette RAM read port. The scan stops early on an exact match.
// The result word appears on match_* with done high for exactly one cycle;
// busy falls in that same cycle, so the next item can be taken there.
// done cannot be held off: the receiver must take the word when it shows.
// Config: palette_size is written on cfg_valid & cfg_ready (always ready);
// the user must write it only while idle; the block does not enforce this.
// Reset (rst, synchronous) clears control state and sets palette_size to
// 256; palette contents are undefined until loaded.
module nearest_palette_color
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 opcode,
  input  logic [OUT_IDX_W-1:0] entry_index,
  input  logic [COLOR_W-1:0]   red,
  input  logic [COLOR_W-1:0]   green,
  input  logic [COLOR_W-1:0]   blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SIZE_W-1:0]    cfg_data,
  output logic                 done,
  output logic [OUT_IDX_W-1:0] match_index,
  output logic [COLOR_W-1:0]   match_red,
  output logic [COLOR_W-1:0]   match_green,
  output logic [COLOR_W-1:0]   match_blue
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);

  npc_cmd_t         cmd;
  npc_status_t      status;
  logic [IDX_W-1:0] rd_addr;

  npc_ctrl #(
    .IDX_W (IDX_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .busy      (busy),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .status    (status)
  );

  npc_datapath #(
    .IDX_W (IDX_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .status      (status),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .done        (done),
    .match_index (match_index),
    .match_red   (match_red),
    .match_green (match_green),
    .match_blue  (match_blue)
  );

endmodule

// File: hw/rtl/npc_checker.sv
`include "nearest_palette_color_defines.svh"

module npc_checker
  import npc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic opcode,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic done
);

  `NPC_ASSERT_NEXT(a_query_busy, start && !busy && opcode == OP_QUERY, busy, "query did not raise busy")
  `NPC_ASSERT_NEXT(a_load_free, start && !busy && opcode == OP_LOAD, !busy, "load raised busy")
  `NPC_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `NPC_ASSERT_NOW(a_done_end, done, $past(busy) && !busy, "done outside end of query")
  `NPC_ASSERT_NOW(a_cfg_idle, cfg_valid && cfg_ready, !busy, "config written while busy")

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .opcode    (opcode),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .done      (done)
);

// File: test/tb_top.sv
module tb_top
  import npc_pkg::*;
();

  localparam int PAL_DEPTH   = 256;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } swatch_t;

  typedef struct {
    logic [OUT_IDX_W-1:0] idx;
    swatch_t              color;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start;
  logic busy;
  logic opcode;
  logic [OUT_IDX_W-1:0] entry_index;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic cfg_valid;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_data;
  logic done;
  logic [OUT_IDX_W-1:0] match_index;
  logic [COLOR_W-1:0] match_red;
  logic [COLOR_W-1:0] match_green;
  logic [COLOR_W-1:0] match_blue;

  swatch_t palette_copy [PAL_DEPTH];
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;
  match_t nearest_q [$];
  int fail_count = 0;
  int stall_cycles;

  nearest_palette_color #(.PALETTE_DEPTH(PAL_DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .entry_index(entry_index),
    .red(red),
    .green(green),
    .blue(blue),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .match_index(match_index),
    .match_red(match_red),
    .match_green(match_green),
    .match_blue(match_blue)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int active_entries(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > PAL_DEPTH) return PAL_DEPTH;
    return int'(s);
  endfunction

  function automatic int channel_gap_sq(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
    int x;
    int y;
    x = int'(a[15:8]);
    y = int'(b[15:8]);
    return (x - y) * (x - y);
  endfunction

  function automatic match_t nearest_match(swatch_t q);
    int count;
    int best;
    int gap;
    int least;
    match_t m;
    count = active_entries(size_reg);
    best = 0;
    least = int'(DIST_START);
    for (int i = 0; i < count; i++) begin
      gap = channel_gap_sq(palette_copy[i].r, q.r) + channel_gap_sq(palette_copy[i].g, q.g)
          + channel_gap_sq(palette_copy[i].b, q.b);
      if (gap < least) begin
        least = gap;
        best = i;
        if (gap == 0) break;
      end
    end
    m.idx = best[OUT_IDX_W-1:0];
    m.color = palette_copy[best];
    return m;
  endfunction

  function automatic swatch_t random_swatch();
    swatch_t s;
    s.r = COLOR_W'($urandom_range(0, 65535));
    s.g = COLOR_W'($urandom_range(0, 65535));
    s.b = COLOR_W'($urandom_range(0, 65535));
    return s;
  endfunction

  // same upper bytes, fresh low bytes
  function automatic swatch_t shade_of(swatch_t s);
    swatch_t t;
    t.r = {s.r[15:8], 8'($urandom_range(0, 255))};
    t.g = {s.g[15:8], 8'($urandom_range(0, 255))};
    t.b = {s.b[15:8], 8'($urandom_range(0, 255))};
    return t;
  endfunction

  function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] c);
    int k;
    int j;
    j = $urandom_range(0, 6);
    k = int'(c[15:8]) + j - 3;
    if (k < 0) k = 0;
    if (k > 255) k = 255;
    return {k[7:0], 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return SIZE_W'($urandom_range(1, 16));
    if (p < 80) return SIZE_W'($urandom_range(17, 255));
    if (p < 90) return 9'd256;
    if (p < 95) return SIZE_W'($urandom_range(257, 511));
    if (p < 97) return 9'd0;
    return 9'd1;
  endfunction

  task automatic send_word(input logic op, input logic [OUT_IDX_W-1:0] idx, input swatch_t c);
    start <= 1'b1;
    opcode <= op;
    entry_index <= idx;
    red <= c.r;
    green <= c.g;
    blue <= c.b;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_LOAD) palette_copy[idx] = c;
    else nearest_q.push_back(nearest_match(c));
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic set_palette_size(input logic [SIZE_W-1:0] v);
    start <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg = v;
  endtask

  task automatic send_random_item();
    int eff;
    int kind;
    swatch_t c;
    swatch_t base;
    logic [OUT_IDX_W-1:0] idx;
    eff = active_entries(size_reg);
    idx = OUT_IDX_W'($urandom_range(0, 255));
    base = palette_copy[$urandom_range(0, eff - 1)];
    if ($urandom_range(0, 99) < 65) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) c = shade_of(base);
      else if (kind < 7) c = '{nudge(base.r), nudge(base.g), nudge(base.b)};
      else c = random_swatch();
      send_word(OP_QUERY, idx, c);
    end else begin
      if ($urandom_range(0, 1) == 1) idx = OUT_IDX_W'($urandom_range(0, eff - 1));
      if ($urandom_range(0, 9) < 3) c = shade_of(palette_copy[$urandom_range(0, 255)]);
      else c = random_swatch();
      send_word(OP_LOAD, idx, c);
    end
  endtask

  task automatic run_phase(input int len, input bit quiet);
    for (int n = 0; n < len; n++) begin
      if (!quiet && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 17));
      send_random_item();
    end
  endtask

  // every entry written before any query; some entries share upper bytes
  task automatic test_palette_fill();
    swatch_t c;
    for (int i = 0; i < PAL_DEPTH; i++) begin
      if (i > 0 && $urandom_range(0, 4) == 0) c = shade_of(palette_copy[$urandom_range(0, i - 1)]);
      else c = random_swatch();
      if ($urandom_range(0, 5) == 0) idle_for($urandom_range(1, 17));
      send_word(OP_LOAD, i[OUT_IDX_W-1:0], c);
    end
  endtask

  // no register write yet: full palette searched
  task automatic test_reset_size();
    send_word(OP_QUERY, 8'h00, palette_copy[PAL_DEPTH-1]);
    send_word(OP_QUERY, 8'hFF, random_swatch());
  endtask

  task automatic test_corner_colors();
    set_palette_size(9'd1);
    send_word(OP_LOAD, 8'h00, '{16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_word(OP_QUERY, 8'hFF, '{16'h0000, 16'h0000, 16'h0000});
    send_word(OP_QUERY, 8'h00, '{16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_word(OP_QUERY, 8'h5A, '{16'h8000, 16'h7FFF, 16'h00FF});
    set_palette_size(9'd0);
    send_word(OP_QUERY, 8'hA5, '{16'h1234, 16'hABCD, 16'h5555});
    send_word(OP_LOAD, 8'h01, '{16'h00FF, 16'h00FF, 16'h00FF});
    send_word(OP_LOAD, 8'h02, '{16'h0000, 16'h0000, 16'h0000});
    set_palette_size(9'd3);
    send_word(OP_QUERY, 8'h00, '{16'h0012, 16'h0034, 16'h0056});
    send_word(OP_QUERY, 8'h00, '{16'hFF00, 16'h0000, 16'h0000});
    send_word(OP_QUERY, 8'h00, '{16'h8000, 16'h8000, 16'h8000});
  endtask

  task automatic test_size_clamp();
    set_palette_size(9'd256);
    send_word(OP_QUERY, 8'h00, palette_copy[PAL_DEPTH-1]);
    set_palette_size(9'd511);
    send_word(OP_QUERY, 8'hFF, palette_copy[PAL_DEPTH-1]);
    set_palette_size(9'd257);
    send_word(OP_QUERY, 8'h80, random_swatch());
    set_palette_size(9'd300);
    send_word(OP_QUERY, 8'h7F, shade_of(palette_copy[PAL_DEPTH-2]));
  endtask

  task automatic test_random_mix(input int total);
    int sent;
    int len;
    sent = 0;
    while (sent < total) begin
      set_palette_size(pick_size());
      len = $urandom_range(10, 60);
      run_phase(len, $urandom_range(0, 3) == 0);
      sent += len;
    end
  endtask

  task automatic test_back_to_back(input int total);
    for (int n = 0; n < total; n += 50) begin
      set_palette_size(pick_size());
      run_phase(50, 1'b1);
    end
  endtask

  always @(posedge clk) begin : check_results
    match_t want;
    if (!rst && done) begin
      if (nearest_q.size() == 0) begin
        $error("result word with none expected: index %0d", match_index);
        fail_count++;
      end else begin
        want = nearest_q.pop_front();
        if (match_index !== want.idx) begin
          $error("match_index: expected %0d, got %0d", want.idx, match_index);
          fail_count++;
        end
        if (match_red !== want.color.r) begin
          $error("match_red: expected %h, got %h", want.color.r, match_red);
          fail_count++;
        end
        if (match_green !== want.color.g) begin
          $error("match_green: expected %h, got %h", want.color.g, match_green);
          fail_count++;
        end
        if (match_blue !== want.color.b) begin
          $error("match_blue: expected %h, got %h", want.color.b, match_blue);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    start <= 1'b0;
    opcode <= OP_LOAD;
    entry_index <= '0;
    red <= '0;
    green <= '0;
    blue <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= SIZE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_palette_fill();
    test_reset_size();
    test_corner_colors();
    test_size_clamp();
    test_random_mix(1100);
    test_back_to_back(200);
    start <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/npc_pkg.sv
hw/rtl/npc_ctrl.sv
hw/rtl/npc_datapath.sv
hw/rtl/nearest_palette_color.sv
hw/rtl/npc_checker.sv
test/tb_top.sv
